FILE: rtl/mp2d_pkg.sv
package mp2d_pkg;

  // fixed sizes of the block
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_KERNEL = 8;
  localparam int VALUE_BITS = 16;
  localparam int MAX_PLANE  = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = COL_W + 1;
  localparam int ROW_W   = $clog2(MAX_PLANE);
  localparam int PLANE_W = ROW_W + 1;
  localparam int K_W     = $clog2(MAX_KERNEL) + 1;
  localparam int CFG_W   = PLANE_W;
  localparam int CFG_IDX_W = 2;

  // reciprocal scaling for divide by kernel: q = (x * recip) >> RECIP_SH
  localparam int RECIP_SH = 16;
  localparam int RECIP_W  = RECIP_SH + 1;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  localparam val_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL   = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_HEIGHT   = 2'd2,
    CFG_WIDTH    = 2'd3
  } cfg_idx_t;

  // configuration after clamping, plus values derived from it
  typedef struct packed {
    logic [K_W-1:0]     k;
    logic [K_W-1:0]     km1;
    logic [RECIP_W-1:0] recip;
    logic               k_ok;
    logic [WID_W-1:0]   w;
    logic [PLANE_W-1:0] h;
    logic [PLANE_W-1:0] c;
    logic [WID_W-1:0]   nwx;
    logic [PLANE_W-1:0] nwy;
  } dcfg_t;

  // one word at the read-modify-write stage
  typedef struct packed {
    logic             valid;
    val_t             v;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] ch;
    logic [ROW_W-1:0] qrow;
    logic [COL_W-1:0] qcol;
    logic             inwin;
    logic             mz;
    logic             fold;
    logic             emit;
    logic             last;
  } item_t;

  // one result word
  typedef struct packed {
    val_t             pooled;
    logic [ROW_W-1:0] ch;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             last;
  } res_t;

  // ceil(2^RECIP_SH / k), zero for an unusable kernel
  function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mp2d_ram.sv
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mp2d_index.sv
module mp2d_index (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mp2d_pkg::dcfg_t                     dcfg,
  input  logic                                adv,
  input  logic                                accept,
  input  logic signed [mp2d_pkg::VALUE_BITS-1:0] sample,
  output logic [mp2d_pkg::COL_W-1:0]          rd_addr,
  output mp2d_pkg::item_t                     item
);
  import mp2d_pkg::*;

  localparam int PCOL_W = COL_W + RECIP_W;
  localparam int PROW_W = ROW_W + RECIP_W;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] ch_r, ch_nxt;

  logic              a_valid_r;
  val_t              a_v_r;
  logic [COL_W-1:0]  a_col_r;
  logic [ROW_W-1:0]  a_row_r;
  logic [ROW_W-1:0]  a_ch_r;
  logic [PCOL_W-1:0] a_pcol_r;
  logic [PROW_W-1:0] a_prow_r;

  item_t b_r, b_nxt;

  logic [COL_W-1:0]     qcol;
  logic [ROW_W-1:0]     qrow;
  logic [COL_W+K_W-1:0] qcol_k;
  logic [ROW_W+K_W-1:0] qrow_k;
  logic [COL_W-1:0]     ncol;
  logic [ROW_W-1:0]     mrow;
  logic [K_W-1:0]       m;
  logic [K_W-1:0]       n;
  logic                 inwin;

  // raster position advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ch_nxt  = ch_r;
    if (({1'b0, col_r} + WID_W'(1)) >= dcfg.w) begin
      col_nxt = '0;
      if (({1'b0, row_r} + PLANE_W'(1)) >= dcfg.h) begin
        row_nxt = '0;
        if (({1'b0, ch_r} + PLANE_W'(1)) >= dcfg.c) begin
          ch_nxt = '0;
        end else begin
          ch_nxt = ch_r + ROW_W'(1);
        end
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // first stage: scaled products for divide by kernel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_v_r    <= sample;
      a_col_r  <= col_r;
      a_row_r  <= row_r;
      a_ch_r   <= ch_r;
      a_pcol_r <= PCOL_W'(col_r) * PCOL_W'(dcfg.recip);
      a_prow_r <= PROW_W'(row_r) * PROW_W'(dcfg.recip);
    end
  end

  // second stage: quotients, remainders and window flags
  always_comb begin
    qcol   = a_pcol_r[RECIP_SH +: COL_W];
    qrow   = a_prow_r[RECIP_SH +: ROW_W];
    qcol_k = (COL_W+K_W)'(qcol) * (COL_W+K_W)'(dcfg.k);
    qrow_k = (ROW_W+K_W)'(qrow) * (ROW_W+K_W)'(dcfg.k);
    ncol   = a_col_r - qcol_k[COL_W-1:0];
    mrow   = a_row_r - qrow_k[ROW_W-1:0];
    n      = ncol[K_W-1:0];
    m      = mrow[K_W-1:0];
    inwin  = dcfg.k_ok && ({1'b0, qcol} < dcfg.nwx) && ({1'b0, qrow} < dcfg.nwy);

    b_nxt.valid = a_valid_r;
    b_nxt.v     = a_v_r;
    b_nxt.col   = a_col_r;
    b_nxt.ch    = a_ch_r;
    b_nxt.qrow  = qrow;
    b_nxt.qcol  = qcol;
    b_nxt.inwin = inwin;
    b_nxt.mz    = (m == '0);
    b_nxt.fold  = inwin && (m == dcfg.km1);
    b_nxt.emit  = inwin && (m == dcfg.km1) && (n == dcfg.km1);
    b_nxt.last  = (({1'b0, a_ch_r} + PLANE_W'(1)) >= dcfg.c)
                  && (({1'b0, qrow} + PLANE_W'(1)) == dcfg.nwy)
                  && (({1'b0, qcol} + WID_W'(1)) == dcfg.nwx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r.valid <= b_nxt.valid;
    end
    if (adv) begin
      b_r.v     <= b_nxt.v;
      b_r.col   <= b_nxt.col;
      b_r.ch    <= b_nxt.ch;
      b_r.qrow  <= b_nxt.qrow;
      b_r.qcol  <= b_nxt.qcol;
      b_r.inwin <= b_nxt.inwin;
      b_r.mz    <= b_nxt.mz;
      b_r.fold  <= b_nxt.fold;
      b_r.emit  <= b_nxt.emit;
      b_r.last  <= b_nxt.last;
    end
  end

  assign rd_addr = a_col_r;
  assign item    = b_r;

endmodule

FILE: rtl/mp2d_pool.sv
module mp2d_pool (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [mp2d_pkg::COL_W-1:0] rd_addr,
  input  mp2d_pkg::item_t            item,
  output logic                       res_valid,
  output mp2d_pkg::res_t             res
);
  import mp2d_pkg::*;

  logic [VALUE_BITS-1:0] rd_data;
  logic                  we;
  logic                  fwd_hit_r;
  val_t                  fwd_data_r;
  val_t                  prev;
  val_t                  colmax;
  val_t                  wnew;
  val_t                  wmax_r, wmax_nxt;

  // line store of partial column maxima
  mp2d_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (item.col),
    .wdata (colmax),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // column max, window fold
  always_comb begin
    prev     = fwd_hit_r ? fwd_data_r : val_t'(rd_data);
    colmax   = (!item.mz && (prev > item.v)) ? prev : item.v;
    wnew     = (colmax > wmax_r) ? colmax : wmax_r;
    we       = item.valid && item.inwin && adv;
    wmax_nxt = wmax_r;
    if (item.valid && item.fold) begin
      wmax_nxt = item.emit ? VAL_MIN : wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmax_r <= VAL_MIN;
    end else if (adv) begin
      wmax_r <= wmax_nxt;
    end
  end

  // bypass for a write to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      fwd_hit_r <= we && (item.col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data_r <= colmax;
    end
  end

  assign res_valid   = item.valid && item.emit;
  assign res.pooled  = wnew;
  assign res.ch      = item.ch;
  assign res.orow    = item.qrow;
  assign res.ocol    = item.qcol;
  assign res.last    = item.last;

endmodule

FILE: rtl/mp2d_skid.sv
module mp2d_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  mp2d_pkg::res_t push_data,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output mp2d_pkg::res_t out_data
);
  import mp2d_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;
  logic out_free;
  logic push_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign push_ok  = push_valid && !skid_valid_r;

  // output word and one spare word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push_ok;
      skid_valid_r <= 1'b0;
    end else if (push_ok) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push_ok) begin
      skid_data_r <= push_data;
    end
  end

  assign adv       = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/max_pooling_2d_top.sv
// Streaming non-overlapping K-by-K max pooling, signed Q8.8 values.
// Input channel: one sample word per accepted cycle (in_valid high, in_stall
// low), raster order channel, row, column. Result channel: one word per
// complete window, carrying the window maximum, its channel, output row and
// output column, and a flag on the last window of the volume.
// Configuration: kernel, channel count, height and width, written through
// cfg_valid/cfg_index/cfg_data while the block is idle; cfg_ready is always
// high. Derived settings are registered, so a sample word accepted at the
// edge right after a write still sees the old values; leave one idle cycle.
// Throughput is one sample per cycle while in_stall is low: the line store
// is read one stage ahead of its write-back, with a bypass for back-to-back
// hits on the same column. An accepted bottom-right sample passes the first
// stage, the second stage and the output register before out_valid rises.
// A stall on the result side parks one finished word in a spare register;
// in_stall rises only once that register is full, so a stalled result costs
// the input side at most that one word of slack.
// Reset clears positions, window max and all valid flags; the line store
// needs no clearing since each window starts by overwriting its entries.
module max_pooling_2d_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mp2d_pkg::VALUE_BITS-1:0] in_sample_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mp2d_pkg::VALUE_BITS-1:0] out_pooled_value,
  output logic [mp2d_pkg::ROW_W-1:0]             out_channel,
  output logic [mp2d_pkg::ROW_W-1:0]             out_row,
  output logic [mp2d_pkg::COL_W-1:0]             out_col,
  output logic                                   out_last_of_frame,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mp2d_pkg::CFG_W-1:0]             cfg_data
);
  import mp2d_pkg::*;

  localparam int NWX_P = WID_W + RECIP_W;
  localparam int NWY_P = PLANE_W + RECIP_W;

  logic [K_W-1:0]     kernel_r;
  logic [PLANE_W-1:0] chans_r;
  logic [PLANE_W-1:0] height_r;
  logic [WID_W-1:0]   width_r;

  dcfg_t dcfg_r, dcfg_nxt;
  logic [NWX_P-1:0] nwx_p;
  logic [NWY_P-1:0] nwy_p;

  logic  adv;
  logic  accept;
  logic [COL_W-1:0] rd_addr;
  item_t item;
  logic  res_valid;
  res_t  res;
  res_t  out_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= K_W'(2);
      chans_r  <= PLANE_W'(1);
      height_r <= PLANE_W'(1);
      width_r  <= WID_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KERNEL:   kernel_r <= cfg_data[K_W-1:0];
        CFG_CHANNELS: chans_r  <= cfg_data[PLANE_W-1:0];
        CFG_HEIGHT:   height_r <= cfg_data[PLANE_W-1:0];
        CFG_WIDTH:    width_r  <= cfg_data[WID_W-1:0];
      endcase
    end
  end

  // clamped sizes and whole-window counts
  always_comb begin
    dcfg_nxt.k     = kernel_r;
    dcfg_nxt.km1   = kernel_r - K_W'(1);
    dcfg_nxt.recip = recip_of(kernel_r);
    dcfg_nxt.k_ok  = (dcfg_nxt.recip != '0);
    if (width_r == '0) begin
      dcfg_nxt.w = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      dcfg_nxt.w = WID_W'(MAX_WIDTH);
    end else begin
      dcfg_nxt.w = width_r;
    end
    if (height_r == '0) begin
      dcfg_nxt.h = PLANE_W'(1);
    end else if (height_r > PLANE_W'(MAX_PLANE)) begin
      dcfg_nxt.h = PLANE_W'(MAX_PLANE);
    end else begin
      dcfg_nxt.h = height_r;
    end
    if (chans_r == '0) begin
      dcfg_nxt.c = PLANE_W'(1);
    end else if (chans_r > PLANE_W'(MAX_PLANE)) begin
      dcfg_nxt.c = PLANE_W'(MAX_PLANE);
    end else begin
      dcfg_nxt.c = chans_r;
    end
    nwx_p = NWX_P'(dcfg_nxt.w) * NWX_P'(dcfg_nxt.recip);
    nwy_p = NWY_P'(dcfg_nxt.h) * NWY_P'(dcfg_nxt.recip);
    dcfg_nxt.nwx = nwx_p[RECIP_SH +: WID_W];
    dcfg_nxt.nwy = nwy_p[RECIP_SH +: PLANE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcfg_r <= '0;
    end else begin
      dcfg_r <= dcfg_nxt;
    end
  end

  // input handshake
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  mp2d_index u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .dcfg    (dcfg_r),
    .adv     (adv),
    .accept  (accept),
    .sample  (in_sample_value),
    .rd_addr (rd_addr),
    .item    (item)
  );

  mp2d_pool u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .rd_addr   (rd_addr),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mp2d_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_data  (res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_pooled_value  = out_data.pooled;
  assign out_channel       = out_data.ch;
  assign out_row           = out_data.orow;
  assign out_col           = out_data.ocol;
  assign out_last_of_frame = out_data.last;

endmodule

FILE: rtl/mp2d_checker.sv
module mp2d_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [mp2d_pkg::VALUE_BITS-1:0] out_pooled_value,
  input logic [mp2d_pkg::ROW_W-1:0]             out_channel,
  input logic [mp2d_pkg::ROW_W-1:0]             out_row,
  input logic [mp2d_pkg::COL_W-1:0]             out_col,
  input logic                                   out_last_of_frame
);
  import mp2d_pkg::*;

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pooled_value) && $stable(out_channel)
      && $stable(out_row) && $stable(out_col) && $stable(out_last_of_frame))
    else $error("result payload changed under stall");

  // input side stalls only when a result word is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result word");

  // input stall clears once a pending word is taken
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall held after result taken");

  // reset empties the output side
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind max_pooling_2d_top mp2d_checker u_checker (.*);

FILE: sim/tb.sv
module tb;
  import mp2d_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_GAP   = 6;
  localparam int QUIET_LIMIT = 2000;

  // expected pooled windows, tracked from the sample stream and register writes
  class pool_predictor;
    int unsigned k_reg, chans_reg, height_reg, width_reg;
    int unsigned col_pos, row_pos, ch_pos;
    int unsigned windowed_samples;
    int unsigned errors;
    val_t        win_max;
    val_t        col_max [MAX_WIDTH];
    res_t        pending [$];

    function new();
      k_reg = 2;
      chans_reg = 1;
      height_reg = 1;
      width_reg = 1;
      col_pos = 0;
      row_pos = 0;
      ch_pos = 0;
      windowed_samples = 0;
      errors = 0;
      win_max = VAL_MIN;
      foreach (col_max[i]) col_max[i] = '0;
    endfunction

    // zero counts as one, anything above the limit as the limit
    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (cfg_idx_t'(idx))
        CFG_KERNEL:   k_reg = data[K_W-1:0];
        CFG_CHANNELS: chans_reg = data;
        CFG_HEIGHT:   height_reg = data;
        CFG_WIDTH:    width_reg = data[WID_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted sample word
    function void take_sample(val_t v);
      int unsigned w, h, c, k, nwx, nwy, m, n;
      val_t cm;
      res_t r;
      w = fit(width_reg, MAX_WIDTH);
      h = fit(height_reg, MAX_PLANE);
      c = fit(chans_reg, MAX_PLANE);
      k = k_reg;
      if (k >= 1 && k <= MAX_KERNEL) begin
        nwx = w / k;
        nwy = h / k;
        if (col_pos < nwx * k && row_pos < nwy * k) begin
          windowed_samples++;
          m = row_pos % k;
          n = col_pos % k;
          // fold the line store entry unless this is the window's top row
          cm = v;
          if (m != 0 && col_max[col_pos] > cm) cm = col_max[col_pos];
          col_max[col_pos] = cm;
          if (m == k - 1) begin
            if (cm > win_max) win_max = cm;
            if (n == k - 1) begin
              r.pooled = win_max;
              r.ch     = ch_pos[ROW_W-1:0];
              r.orow   = 10'(row_pos / k);
              r.ocol   = 8'(col_pos / k);
              r.last   = (ch_pos + 1 >= c) && (row_pos / k + 1 == nwy) &&
                         (col_pos / k + 1 == nwx);
              pending.push_back(r);
              win_max = VAL_MIN;
            end
          end
        end
      end
      // raster advance, a counter at or past its limit wraps
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          ch_pos = (ch_pos + 1 >= c) ? 0 : ch_pos + 1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // one accepted result word against the oldest expected window
    function void match_window(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected word: val %0d ch %0d row %0d col %0d last %0b",
                             got.pooled, got.ch, got.orow, got.ocol, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.pooled !== want.pooled || got.ch !== want.ch || got.orow !== want.orow ||
          got.ocol !== want.ocol || got.last !== want.last)
        note_error($sformatf({"window mismatch: expected val %0d ch %0d row %0d col %0d ",
                              "last %0b, got val %0d ch %0d row %0d col %0d last %0b"},
                             want.pooled, want.ch, want.orow, want.ocol, want.last,
                             got.pooled, got.ch, got.orow, got.ocol, got.last));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  val_t                   in_sample_value;
  logic                   out_valid;
  logic                   out_stall;
  val_t                   out_pooled_value;
  logic [ROW_W-1:0]       out_channel;
  logic [ROW_W-1:0]       out_row;
  logic [COL_W-1:0]       out_col;
  logic                   out_last_of_frame;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  pool_predictor pool_pred;
  int unsigned   send_gap_pct;
  int unsigned   recv_stall_pct;
  bit            hold_request;
  int unsigned   quiet_cycles;

  max_pooling_2d_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pooled_value  (out_pooled_value),
    .out_channel       (out_channel),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // observe accepted words on all three channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pool_pred.take_sample(in_sample_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pool_pred.match_window({out_pooled_value, out_channel, out_row, out_col,
                              out_last_of_frame});
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) pool_pred.set_reg(cfg_index, cfg_data);
  end

  // watchdog on cycles with no accepted word anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic val_t rand_sample();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return 16'sh7FFF;
      2:       return val_t'($urandom_range(0, 16) - 8);
      default: return val_t'($urandom);
    endcase
  endfunction

  // zero, oversized within the register field, or in range
  function automatic int unsigned odd_dim(int unsigned hi, int unsigned field_max);
    case ($urandom_range(2))
      0:       return 0;
      1:       return $urandom_range(hi + 1, field_max);
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  // all tasks start and end on a falling edge
  task automatic send_sample(input val_t v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every expected window is out and the pipe has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pool_pred.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned k, c, h, w);
    drain();
    write_reg(CFG_KERNEL, k);
    write_reg(CFG_CHANNELS, c);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_WIDTH, w);
  endtask

  task automatic run_volume(input int unsigned k, c, h, w, count);
    configure(k, c, h, w);
    repeat (count) send_sample(rand_sample());
  endtask

  // bring the raster position back to the start of a volume
  task automatic realign();
    if (pool_pred.col_pos != 0 || pool_pred.row_pos != 0 || pool_pred.ch_pos != 0) begin
      configure(1, 1, 1, 1);
      send_sample(rand_sample());
    end
  endtask

  task automatic random_phase();
    int unsigned k, c, h, w, vol, pick;
    pick = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? $urandom_range(5, MAX_KERNEL) : $urandom_range(1, 4);
    w = k * $urandom_range(1, (k > 4) ? 2 : 4) +
        (($urandom_range(2) == 0) ? $urandom_range(0, k - 1) : 0);
    h = k * $urandom_range(1, 2) + (($urandom_range(2) == 0) ? $urandom_range(0, k - 1) : 0);
    c = $urandom_range(1, 2);
    vol = w * h * c;
    if (pick < 70) begin
      // whole volume with random content
      realign();
      run_volume(k, c, h, w, vol);
    end else if (pick < 78) begin
      // rejected kernel, or a kernel wider than the plane
      if ($urandom_range(1)) begin
        k = $urandom_range(MAX_KERNEL, 15);
        if (k == MAX_KERNEL) k = 0;
      end else begin
        k = $urandom_range(2, MAX_KERNEL);
        w = $urandom_range(1, k - 1);
      end
      realign();
      run_volume(k, c, h, w, w * h * c);
    end else if (pick < 90) begin
      // zero or oversized sizes, cut off mid-volume
      run_volume($urandom_range(1, MAX_KERNEL), odd_dim(MAX_PLANE, 2047),
                 odd_dim(MAX_PLANE, 2047), odd_dim(MAX_WIDTH, 511), $urandom_range(8, 160));
    end else begin
      // broken volume: next settings land with the counters mid-plane
      run_volume(k, c, h, w, $urandom_range(1, vol));
    end
  endtask

  initial begin : main
    pool_pred = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KERNEL;
    cfg_data = '0;
    hold_request = 1'b0;
    quiet_cycles = 0;
    send_gap_pct = 13;
    recv_stall_pct = 49;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: kernel of two over a one-by-one plane gives nothing
    send_sample(16'sh1234);
    send_sample(-16'sd5);

    // zero sizes count as one, every word is its own window
    configure(1, 0, 0, 0);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);

    // trailing row and column are ignored even when larger
    configure(2, 1, 3, 3);
    send_sample(16'sd10);
    send_sample(16'sd20);
    send_sample(16'sh7FFF);
    send_sample(16'sd30);
    send_sample(-16'sd5);
    send_sample(16'sh7FFE);
    repeat (3) send_sample(16'sh7FFF);

    // width shrinks mid-volume, column past the new limit wraps
    configure(2, 1, 4, 4);
    repeat (6) send_sample(rand_sample());
    drain();
    write_reg(CFG_WIDTH, 2);
    repeat (5) send_sample(rand_sample());

    // rejected kernel still advances the raster position
    configure(15, 1, 2, 2);
    repeat (3) send_sample(rand_sample());
    drain();
    write_reg(CFG_KERNEL, 2);
    repeat (5) send_sample(rand_sample());

    // widest row with kernel one, this also loads every line store entry
    realign();
    run_volume(1, 1, 1, MAX_WIDTH, MAX_WIDTH);
    while (pool_pred.windowed_samples < 420) random_phase();

    send_gap_pct = 49;
    recv_stall_pct = 13;
    while (pool_pred.windowed_samples < 700) random_phase();

    // no idling; every channel of the deepest volume is a window, with one long hold-off
    send_gap_pct = 0;
    recv_stall_pct = 0;
    realign();
    configure(1, MAX_PLANE, 1, 1);
    hold_request = 1'b1;
    repeat (MAX_PLANE) send_sample(rand_sample());
    while (pool_pred.windowed_samples < 1600) random_phase();

    drain();
    if (pool_pred.errors == 0 && pool_pred.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
